[rtl/rspd_pkg.sv]
package rspd_pkg;

	localparam int PREVIOUS_WINDOW = 30;
	localparam int NEXT_WINDOW = 10;
	localparam int COUNT_WIDTH = 16;

	localparam int IN_COUNT_WIDTH = 16;
	localparam int THR_WIDTH = 10;
	localparam int HOLD_WIDTH = 16;
	localparam int NSUM_WIDTH = 20;
	localparam int PSUM_WIDTH = 21;
	localparam int TICKS_WIDTH = 17;
	localparam int INDEX_WIDTH = 32;
	localparam int CFG_INDEX_WIDTH = 8;
	localparam int CFG_DATA_WIDTH = 16;

	localparam logic [NSUM_WIDTH-1:0] NSUM_MAX = '1;
	localparam logic [PSUM_WIDTH-1:0] PSUM_MAX = '1;
	localparam logic [TICKS_WIDTH-1:0] TICKS_MAX = '1;
	localparam logic [INDEX_WIDTH-1:0] EARLY_LIMIT = 32'd10;

	localparam logic [THR_WIDTH-1:0] THR_RESET = 10'd10;
	localparam logic [HOLD_WIDTH-1:0] HOLD_RESET = 16'd1000;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_RISE_THRESHOLD = 8'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_HOLDOFF_BINS = 8'd1;

	// one bin slot leaving the delay line toward the test logic
	typedef struct packed {
		logic v;        // a bin was pushed
		logic test;     // the bin at the window boundary is due for a test
		logic grp_end;  // last slot that feeds the current result
		logic eos;      // final slot of the stream flush
	} slot_t;

endpackage

[rtl/rspd_line.sv]
module rspd_line #(
	parameter int PREVIOUS_WINDOW = rspd_pkg::PREVIOUS_WINDOW,
	parameter int NEXT_WINDOW = rspd_pkg::NEXT_WINDOW,
	parameter int COUNT_WIDTH = rspd_pkg::COUNT_WIDTH,
	parameter int NSW = $clog2(NEXT_WINDOW) + COUNT_WIDTH,
	parameter int PSW = $clog2(PREVIOUS_WINDOW) + COUNT_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   push_v,
	input  logic [COUNT_WIDTH-1:0] push_val,
	input  logic                   push_grp_end,
	input  logic                   push_eos,
	output rspd_pkg::slot_t        slot_s1,
	output logic [NSW-1:0]         nsum_s1,
	output logic [PSW-1:0]         psum_s1
);

	localparam int LD = PREVIOUS_WINDOW + NEXT_WINDOW;
	localparam int FLW = (NEXT_WINDOW > 1) ? $clog2(NEXT_WINDOW) : 1;
	localparam logic [FLW-1:0] FILL_FULL = FLW'(NEXT_WINDOW - 1);

	logic [COUNT_WIDTH-1:0] line_s1 [LD];
	logic [FLW-1:0]         fill_q;
	logic                   due;
	logic                   clear;
	logic [COUNT_WIDTH-1:0] cross_val;
	logic [COUNT_WIDTH-1:0] old_val;

	assign due = (fill_q == FILL_FULL);
	assign clear = slot_s1.v && slot_s1.eos;
	assign cross_val = line_s1[NEXT_WINDOW-1];
	assign old_val = line_s1[LD-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LD; k++) begin
				line_s1[k] <= '0;
			end
			nsum_s1 <= '0;
			psum_s1 <= '0;
			fill_q <= '0;
			slot_s1 <= '0;
		end else if (en) begin
			if (clear) begin
				// stream closed: back to an empty line
				for (int k = 0; k < LD; k++) begin
					line_s1[k] <= '0;
				end
				nsum_s1 <= '0;
				psum_s1 <= '0;
				fill_q <= '0;
				slot_s1 <= '0;
			end else if (push_v) begin
				for (int k = LD - 1; k > 0; k--) begin
					line_s1[k] <= line_s1[k-1];
				end
				line_s1[0] <= push_val;
				nsum_s1 <= nsum_s1 + NSW'(push_val) - NSW'(cross_val);
				psum_s1 <= psum_s1 + PSW'(cross_val) - PSW'(old_val);
				if (!due) begin
					fill_q <= fill_q + 1'b1;
				end
				slot_s1.v <= 1'b1;
				slot_s1.test <= due;
				slot_s1.grp_end <= push_grp_end;
				slot_s1.eos <= push_eos;
			end else begin
				slot_s1 <= '0;
			end
		end
	end

endmodule

[rtl/rspd_test.sv]
module rspd_test #(
	parameter int PREVIOUS_WINDOW = rspd_pkg::PREVIOUS_WINDOW,
	parameter int NEXT_WINDOW = rspd_pkg::NEXT_WINDOW,
	parameter int NSW = $clog2(NEXT_WINDOW) + rspd_pkg::COUNT_WIDTH,
	parameter int PSW = $clog2(PREVIOUS_WINDOW) + rspd_pkg::COUNT_WIDTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  rspd_pkg::slot_t                     slot_s1,
	input  logic [NSW-1:0]                      nsum_s1,
	input  logic [PSW-1:0]                      psum_s1,
	input  logic [rspd_pkg::THR_WIDTH-1:0]      thr,
	input  logic [rspd_pkg::HOLD_WIDTH-1:0]     holdoff,
	input  logic                                m_tready,
	output logic                                emit,
	output logic                                m_tvalid,
	output logic [rspd_pkg::INDEX_WIDTH-1:0]    m_tdata,
	output logic                                m_tuser,
	output logic                                m_tlast
);

	localparam int NCW = (NSW > rspd_pkg::NSUM_WIDTH) ? NSW : rspd_pkg::NSUM_WIDTH;
	localparam int PCW = (PSW > rspd_pkg::PSUM_WIDTH) ? PSW : rspd_pkg::PSUM_WIDTH;
	localparam int CMPW = 22 + $clog2(NEXT_WINDOW) + $clog2(PREVIOUS_WINDOW);
	localparam int TW = rspd_pkg::TICKS_WIDTH;
	localparam int IW = rspd_pkg::INDEX_WIDTH;

	logic [IW-1:0] idx_q;
	logic [TW-1:0] ticks_q;
	logic          recent_q;
	logic          grp_found_q;
	logic [IW-1:0] grp_where_q;

	logic [NCW-1:0] n_ext;
	logic [PCW-1:0] p_ext;
	logic [rspd_pkg::NSUM_WIDTH-1:0] nsat;
	logic [rspd_pkg::PSUM_WIDTH-1:0] psat;
	logic [CMPW-1:0] lhs;
	logic [CMPW-1:0] rhs;
	logic [TW-1:0]   ticks_inc;
	logic            recent_inc;
	logic            skip;
	logic            do_test;
	logic            hit;
	logic            found_any;
	logic [IW-1:0]   where_sel;

	assign n_ext = NCW'(nsum_s1);
	assign p_ext = PCW'(psum_s1);
	assign nsat = (n_ext > NCW'(rspd_pkg::NSUM_MAX)) ? rspd_pkg::NSUM_MAX
		: n_ext[rspd_pkg::NSUM_WIDTH-1:0];
	assign psat = (p_ext > PCW'(rspd_pkg::PSUM_MAX)) ? rspd_pkg::PSUM_MAX
		: p_ext[rspd_pkg::PSUM_WIDTH-1:0];

	// next mean above previous mean plus margin, cross-multiplied
	assign lhs = CMPW'(nsat) * CMPW'(PREVIOUS_WINDOW);
	assign rhs = CMPW'(psat) * CMPW'(NEXT_WINDOW)
		+ CMPW'(thr) * CMPW'(NEXT_WINDOW * PREVIOUS_WINDOW);

	assign ticks_inc = (ticks_q < rspd_pkg::TICKS_MAX) ? ticks_q + 1'b1 : ticks_q;
	assign recent_inc = (ticks_inc > TW'(holdoff)) ? 1'b0 : recent_q;
	assign skip = recent_inc || (ticks_inc < TW'(holdoff));
	assign do_test = slot_s1.v && slot_s1.test;
	assign hit = do_test && !skip && (idx_q > rspd_pkg::EARLY_LIMIT) && (lhs > rhs);

	// keep the earliest onset of the group
	assign found_any = grp_found_q || hit;
	assign where_sel = grp_found_q ? grp_where_q : idx_q;
	assign emit = slot_s1.v && slot_s1.grp_end && (found_any || slot_s1.eos);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			ticks_q <= '0;
			recent_q <= 1'b0;
			grp_found_q <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (en && slot_s1.v) begin
				if (slot_s1.eos) begin
					idx_q <= '0;
					ticks_q <= '0;
					recent_q <= 1'b0;
				end else if (do_test) begin
					idx_q <= idx_q + 1'b1;
					ticks_q <= hit ? '0 : ticks_inc;
					recent_q <= hit || recent_inc;
				end
				if (slot_s1.grp_end) begin
					grp_found_q <= 1'b0;
				end else if (hit) begin
					grp_found_q <= 1'b1;
				end
			end
			if (en && emit) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && slot_s1.v && !slot_s1.grp_end && hit && !grp_found_q) begin
			grp_where_q <= idx_q;
		end
		if (en && emit) begin
			m_tdata <= found_any ? where_sel : '0;
			m_tuser <= found_any;
			m_tlast <= slot_s1.eos;
		end
	end

endmodule

[rtl/rate_step_pulse_detector.sv]
// Output: a bin's result passes from the line's slot register (slot_s1) into the output register;
// for a bin with tlast the result is loaded from the final slot of the flush that follows it.
// Throughput: one bin per cycle while not stalled; a bin with tlast is followed by its flush of
// NEXT_WINDOW-1 zero pushes and a step that tests the final slot and clears the line.
// Outside the flush, input stalls only when a new result meets a full output register not taken.
// Reset (arst_n low, asynchronous): stream state cleared, rise_threshold 10, holdoff_bins 1000.
module rate_step_pulse_detector #(
	parameter int PREVIOUS_WINDOW = rspd_pkg::PREVIOUS_WINDOW,
	parameter int NEXT_WINDOW = rspd_pkg::NEXT_WINDOW,
	parameter int COUNT_WIDTH = rspd_pkg::COUNT_WIDTH
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [rspd_pkg::IN_COUNT_WIDTH-1:0]    s_tdata,   // [15:0] bin_count
	input  logic                                   s_tlast,   // last_bin
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [rspd_pkg::INDEX_WIDTH-1:0]       m_tdata,   // [31:0] pulse_bin
	output logic                                   m_tuser,   // [0] pulse_valid
	output logic                                   m_tlast,   // end_of_stream
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [rspd_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
	input  logic [rspd_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);

	localparam int NSW = $clog2(NEXT_WINDOW) + COUNT_WIDTH;
	localparam int PSW = $clog2(PREVIOUS_WINDOW) + COUNT_WIDTH;
	localparam int FLW = (NEXT_WINDOW > 1) ? $clog2(NEXT_WINDOW) : 1;
	localparam logic [FLW-1:0] FLUSH_LEN = FLW'(NEXT_WINDOW - 1);
	localparam logic [FLW-1:0] FLUSH_ONE = FLW'(1);
	localparam logic SINGLE = (NEXT_WINDOW == 1);

	logic [rspd_pkg::THR_WIDTH-1:0]  thr_q;
	logic [rspd_pkg::HOLD_WIDTH-1:0] hold_q;
	logic [FLW-1:0]                  flush_left_q;

	rspd_pkg::slot_t        slot_s1;
	logic [NSW-1:0]         nsum_s1;
	logic [PSW-1:0]         psum_s1;
	logic                   emit;
	logic                   en;
	logic                   busy;
	logic                   flushing;
	logic                   acc;
	logic                   zero_push;
	logic                   push_v;
	logic [COUNT_WIDTH-1:0] push_val;
	logic                   push_grp_end;
	logic                   push_eos;

	// hold the stream path (config writes still go through) only when a new result would overwrite one not yet taken
	assign en = !(emit && m_tvalid && !m_tready);
	assign flushing = (flush_left_q != '0);
	assign busy = flushing || (slot_s1.v && slot_s1.eos);
	assign s_tready = en && !busy;
	assign acc = s_tvalid && s_tready;
	assign zero_push = en && flushing;
	assign push_v = acc || zero_push;
	assign push_val = acc ? COUNT_WIDTH'(s_tdata) : '0;
	assign push_grp_end = acc ? (!s_tlast || SINGLE) : (flush_left_q == FLUSH_ONE);
	assign push_eos = acc ? (s_tlast && SINGLE) : (flush_left_q == FLUSH_ONE);
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flush_left_q <= '0;
			thr_q <= rspd_pkg::THR_RESET;
			hold_q <= rspd_pkg::HOLD_RESET;
		end else begin
			if (acc && s_tlast) begin
				flush_left_q <= FLUSH_LEN;
			end else if (zero_push) begin
				flush_left_q <= flush_left_q - 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					rspd_pkg::REG_RISE_THRESHOLD: thr_q <= cfg_data[rspd_pkg::THR_WIDTH-1:0];
					rspd_pkg::REG_HOLDOFF_BINS:   hold_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	rspd_line #(
		.PREVIOUS_WINDOW(PREVIOUS_WINDOW),
		.NEXT_WINDOW(NEXT_WINDOW),
		.COUNT_WIDTH(COUNT_WIDTH),
		.NSW(NSW),
		.PSW(PSW)
	) u_line (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.push_v(push_v),
		.push_val(push_val),
		.push_grp_end(push_grp_end),
		.push_eos(push_eos),
		.slot_s1(slot_s1),
		.nsum_s1(nsum_s1),
		.psum_s1(psum_s1)
	);

	rspd_test #(
		.PREVIOUS_WINDOW(PREVIOUS_WINDOW),
		.NEXT_WINDOW(NEXT_WINDOW),
		.NSW(NSW),
		.PSW(PSW)
	) u_test (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.slot_s1(slot_s1),
		.nsum_s1(nsum_s1),
		.psum_s1(psum_s1),
		.thr(thr_q),
		.holdoff(hold_q),
		.m_tready(m_tready),
		.emit(emit),
		.m_tvalid(m_tvalid),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

endmodule
